// ===== design/binned_pair_crossproduct_histogram_assert.svh =====
// assertion macros for the binned pair cross-product histogram
// used by design/binned_pair_crossproduct_histogram.sv, expects aclk and aresetn in scope
`ifndef BINNED_PAIR_CROSSPRODUCT_HISTOGRAM_ASSERT_SVH
`define BINNED_PAIR_CROSSPRODUCT_HISTOGRAM_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPCH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BPCH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BPCH_ASSERT(lbl, prop, msg)
`define BPCH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/bpch_pkg.sv =====
// shared types and constants of the binned pair cross-product histogram
// no dependencies
package bpch_pkg;

    localparam int MAX_INDIVIDUALS = 4096;
    localparam int NUM_BINS        = 247;
    localparam int IDX_W           = 12;
    localparam int N_W             = 13;
    localparam int BIN_W           = 8;
    localparam int CNT_W           = 23;
    localparam int GSUM_W          = 48;
    localparam int CSUM_W          = 56;
    localparam int DIV_W           = 56;

    localparam logic [BIN_W-1:0] NO_BIN   = 8'd247;
    localparam logic [BIN_W-1:0] LAST_BIN = 8'd246;

    localparam logic signed [17:0] EDGE_MIN = -18'sd30000;
    localparam logic signed [17:0] EDGE_S1  = -18'sd2000;
    localparam logic signed [17:0] EDGE_S2  = 18'sd2000;
    localparam logic signed [17:0] EDGE_MAX = 18'sd105000;

    localparam logic [15:0] RECIP_100 = 16'd41944;
    localparam logic [18:0] RECIP_500 = 19'd268436;

    typedef enum logic [1:0] {
        FN_LOAD = 2'd0,
        FN_GRM  = 2'd1,
        FN_READ = 2'd2,
        FN_BAD  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SKIPPED  = 3'd1,
        ST_RANGE    = 3'd2,
        ST_PAST_END = 3'd3,
        ST_BAD_IDX  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RD_I,
        S_RD_J,
        S_ACC,
        S_RD_BIN,
        S_DIV_G,
        S_DIV_C,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        logic signed [GSUM_W-1:0] gsum;
        logic signed [CSUM_W-1:0] csum;
    } bin_entry_t;

endpackage

// ===== design/bpch_div.sv =====
// iterative unsigned divider, one quotient bit per cycle
// depends on bpch_pkg
module bpch_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [bpch_pkg::DIV_W-1:0]      dividend,
    input  logic [bpch_pkg::CNT_W-1:0]      divisor,
    output logic                            done,
    output logic [bpch_pkg::DIV_W-1:0]      quotient
);

    logic [bpch_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [bpch_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [bpch_pkg::CNT_W-1:0] dsr_reg;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [bpch_pkg::CNT_W:0]   trial;
    logic                       fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[bpch_pkg::DIV_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? bpch_pkg::CNT_W'(trial - {1'b0, dsr_reg})
                            : trial[bpch_pkg::CNT_W-1:0];
            quo_next = {quo_reg[bpch_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(bpch_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/binned_pair_crossproduct_histogram.sv =====
// binned pair cross-product histogram, top level
// depends on bpch_pkg, bpch_div and binned_pair_crossproduct_histogram_assert.svh
//
// input stream s_*: s_tuser selects the operation (load phenotype, matrix entry,
// read bin); s_tdata carries the operands. every input transaction gives exactly
// one output transaction on m_*, with the status in m_tuser.
// cfg_* writes num_individuals and is always ready; the user must write it
// only while idle, as the block does not enforce this. phenotypes and present
// flags sit in a 4096-entry memory, bin counts and sums in a 247-entry memory,
// both with registered reads. a valid load writes one phenotype entry; a matrix
// entry does two phenotype reads on one port plus a bin read-modify-write; a bin
// read of an empty bin skips the divisions, otherwise it runs two 56-step
// divisions on the shared bit-serial divider. one item is in work at a time.
// after reset a clearing pass over all 4096 phenotype addresses zeroes both
// memories; s_tready stays low until it ends.
// a result waits in the output register while the receiver stalls; the next
// item is still accepted and its result is held until that register frees.
module binned_pair_crossproduct_histogram (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pheno_index, pheno_value, pheno_present, grm_value, bin_select, pad
    input  logic [55:0]  s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bin_number, pair_count, avg_grm, avg_crossprod, pairs_seen, pairs_used,
    // pairs_out_of_range, matrix_done
    output logic [151:0] m_tdata,
    // status
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [12:0]  cfg_data
);

    bpch_pkg::state_t state_reg, state_next;

    logic [bpch_pkg::N_W-1:0]   nind_reg;
    logic [bpch_pkg::N_W-1:0]   n_eff;
    logic [bpch_pkg::IDX_W-1:0] clr_reg;

    logic [1:0]                 func_reg;
    logic [bpch_pkg::IDX_W-1:0] idx_reg;
    logic signed [15:0]         pval_reg;
    logic                       ppres_reg;
    logic signed [17:0]         grm_reg;
    logic [bpch_pkg::BIN_W-1:0] sel_reg;

    logic [bpch_pkg::N_W-1:0]   row_reg;
    logic [bpch_pkg::IDX_W-1:0] col_reg;
    logic [23:0]                seen_reg;
    logic [22:0]                used_reg;
    logic [22:0]                miss_reg;
    logic [bpch_pkg::IDX_W-1:0] j_reg;
    logic [bpch_pkg::BIN_W-1:0] hit_reg;
    logic [16:0]                pi_reg;
    logic signed [31:0]         prod_reg;

    logic [2:0]                 res_status_reg;
    logic [bpch_pkg::BIN_W-1:0] res_bin_reg;
    logic [22:0]                res_cnt_reg;
    logic signed [17:0]         res_avg_g_reg;
    logic signed [31:0]         res_avg_c_reg;

    logic                       m_valid_reg;
    logic [151:0]               m_data_reg;
    logic [2:0]                 m_user_reg;

    logic [16:0]                pmem [bpch_pkg::MAX_INDIVIDUALS];
    logic [16:0]                prd_reg;
    logic [bpch_pkg::IDX_W-1:0] p_raddr;
    logic                       p_we;
    logic [bpch_pkg::IDX_W-1:0] p_waddr;
    logic [16:0]                p_wdata;

    bpch_pkg::bin_entry_t       bmem [bpch_pkg::NUM_BINS];
    bpch_pkg::bin_entry_t       brd_reg;
    bpch_pkg::bin_entry_t       b_wdata;
    logic [bpch_pkg::BIN_W-1:0] b_raddr;
    logic [bpch_pkg::BIN_W-1:0] b_waddr;
    logic                       b_we;

    logic                       div_start;
    logic                       div_done;
    logic [bpch_pkg::DIV_W-1:0] div_dividend;
    logic [bpch_pkg::DIV_W-1:0] div_quo;
    logic [bpch_pkg::DIV_W-1:0] quo_signed;
    logic [bpch_pkg::DIV_W-1:0] gsum_mag;
    logic [bpch_pkg::DIV_W-1:0] csum_mag;

    logic                       accept;
    logic                       out_free;
    logic                       grm_past_end;
    logic                       grm_skip;
    logic                       load_bad;
    logic                       read_bad;
    logic                       pair_missing;
    logic                       hit_none;

    logic [11:0]                d1;
    logic [27:0]                m1;
    logic [16:0]                d2;
    logic [35:0]                m2;
    logic [8:0]                 q2;
    logic [bpch_pkg::BIN_W-1:0] bin_calc;
    logic signed [17:0]         g_plus;
    logic signed [17:0]         g_minus;

    // config and effective size
    assign cfg_ready = 1'b1;

    always_comb begin
        if (nind_reg < 13'd2) begin
            n_eff = 13'd2;
        end else if (nind_reg > 13'(bpch_pkg::MAX_INDIVIDUALS)) begin
            n_eff = 13'(bpch_pkg::MAX_INDIVIDUALS);
        end else begin
            n_eff = nind_reg;
        end
    end

    // bin lookup, exact fixed-point edges
    always_comb begin
        g_plus  = grm_reg - bpch_pkg::EDGE_S1;
        g_minus = grm_reg - bpch_pkg::EDGE_S2;
        d1 = g_plus[11:0];
        m1 = 28'(d1) * 28'(bpch_pkg::RECIP_100);
        d2 = g_minus[16:0];
        m2 = 36'(d2) * 36'(bpch_pkg::RECIP_500);
        q2 = m2[35:27];
        if (grm_reg < bpch_pkg::EDGE_MIN || grm_reg > bpch_pkg::EDGE_MAX) begin
            bin_calc = bpch_pkg::NO_BIN;
        end else if (grm_reg < bpch_pkg::EDGE_S1) begin
            bin_calc = 8'd0;
        end else if (grm_reg < bpch_pkg::EDGE_S2) begin
            bin_calc = 8'd1 + 8'(m1[27:22]);
        end else if (q2 > 9'd205) begin
            bin_calc = bpch_pkg::LAST_BIN;
        end else begin
            bin_calc = 8'd41 + q2[7:0];
        end
    end

    assign accept       = s_tvalid && s_tready;
    assign out_free     = !m_valid_reg || m_tready;
    assign grm_past_end = row_reg >= n_eff;
    assign grm_skip     = ({1'b0, col_reg} == row_reg) || ({1'b0, col_reg} >= n_eff);
    assign load_bad     = {1'b0, idx_reg} >= n_eff;
    assign read_bad     = sel_reg >= 8'(bpch_pkg::NUM_BINS);
    assign pair_missing = !pi_reg[16] || !prd_reg[16];
    assign hit_none     = hit_reg == bpch_pkg::NO_BIN;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpch_pkg::S_CLEAR: begin
                if (clr_reg == '1) begin
                    state_next = bpch_pkg::S_IDLE;
                end
            end
            bpch_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = bpch_pkg::S_EXEC;
                end
            end
            bpch_pkg::S_EXEC: begin
                case (func_reg)
                    bpch_pkg::FN_GRM: begin
                        state_next = (grm_past_end || grm_skip) ? bpch_pkg::S_OUT
                                                                : bpch_pkg::S_RD_I;
                    end
                    bpch_pkg::FN_READ: begin
                        state_next = read_bad ? bpch_pkg::S_OUT : bpch_pkg::S_RD_BIN;
                    end
                    default: state_next = bpch_pkg::S_OUT;
                endcase
            end
            bpch_pkg::S_RD_I: state_next = bpch_pkg::S_RD_J;
            bpch_pkg::S_RD_J: begin
                state_next = (pair_missing || hit_none) ? bpch_pkg::S_OUT
                                                        : bpch_pkg::S_ACC;
            end
            bpch_pkg::S_ACC: state_next = bpch_pkg::S_OUT;
            bpch_pkg::S_RD_BIN: begin
                state_next = (brd_reg.cnt == '0) ? bpch_pkg::S_OUT : bpch_pkg::S_DIV_G;
            end
            bpch_pkg::S_DIV_G: begin
                if (div_done) begin
                    state_next = bpch_pkg::S_DIV_C;
                end
            end
            bpch_pkg::S_DIV_C: begin
                if (div_done) begin
                    state_next = bpch_pkg::S_OUT;
                end
            end
            bpch_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = bpch_pkg::S_IDLE;
                end
            end
            default: state_next = bpch_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready      = state_reg == bpch_pkg::S_IDLE;
        p_we          = 1'b0;
        p_waddr       = idx_reg;
        p_wdata       = {ppres_reg, pval_reg};
        p_raddr       = row_reg[bpch_pkg::IDX_W-1:0];
        b_we          = 1'b0;
        b_waddr       = hit_reg;
        b_raddr       = sel_reg;
        div_start     = 1'b0;
        div_dividend  = gsum_mag;
        case (state_reg)
            bpch_pkg::S_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = clr_reg;
                p_wdata = '0;
                b_we    = clr_reg < 12'(bpch_pkg::NUM_BINS);
                b_waddr = clr_reg[bpch_pkg::BIN_W-1:0];
            end
            bpch_pkg::S_EXEC: begin
                p_we = (func_reg == bpch_pkg::FN_LOAD) && !load_bad;
            end
            bpch_pkg::S_RD_I: begin
                p_raddr = j_reg;
            end
            bpch_pkg::S_RD_J: begin
                b_raddr = hit_reg;
            end
            bpch_pkg::S_ACC: begin
                b_we = 1'b1;
            end
            bpch_pkg::S_RD_BIN: begin
                div_start = brd_reg.cnt != '0;
            end
            bpch_pkg::S_DIV_G: begin
                div_start    = div_done;
                div_dividend = csum_mag;
            end
            default: ;
        endcase
    end

    always_comb begin
        b_wdata      = brd_reg;
        b_wdata.cnt  = brd_reg.cnt + 23'd1;
        b_wdata.gsum = brd_reg.gsum + 48'(grm_reg);
        b_wdata.csum = brd_reg.csum + 56'(prod_reg);
        if (state_reg == bpch_pkg::S_CLEAR) begin
            b_wdata = '0;
        end
    end

    assign gsum_mag = 56'(brd_reg.gsum[47] ? -brd_reg.gsum : brd_reg.gsum);
    assign csum_mag = brd_reg.csum[55] ? 56'(-brd_reg.csum) : 56'(brd_reg.csum);

    // memories
    always_ff @(posedge aclk) begin
        if (p_we) begin
            pmem[p_waddr] <= p_wdata;
        end
        prd_reg <= pmem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            bmem[b_waddr] <= b_wdata;
        end
        brd_reg <= bmem[b_raddr];
    end

    bpch_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (brd_reg.cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        if (state_reg == bpch_pkg::S_DIV_G) begin
            quo_signed = brd_reg.gsum[47] ? -div_quo : div_quo;
        end else begin
            quo_signed = brd_reg.csum[55] ? -div_quo : div_quo;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpch_pkg::S_CLEAR;
            clr_reg     <= '0;
            nind_reg    <= 13'd2;
            row_reg     <= '0;
            col_reg     <= '0;
            seen_reg    <= '0;
            used_reg    <= '0;
            miss_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == bpch_pkg::S_CLEAR) begin
                clr_reg <= clr_reg + 12'd1;
            end
            if (cfg_valid && cfg_ready) begin
                nind_reg <= cfg_data;
            end
            if (state_reg == bpch_pkg::S_EXEC && func_reg == bpch_pkg::FN_GRM
                && !grm_past_end) begin
                seen_reg <= seen_reg + 24'd1;
                if ({1'b0, col_reg} >= row_reg) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 13'd1;
                end else begin
                    col_reg <= col_reg + 12'd1;
                end
            end
            if (state_reg == bpch_pkg::S_RD_J && !pair_missing && hit_none) begin
                miss_reg <= miss_reg + 23'd1;
            end
            if (state_reg == bpch_pkg::S_ACC) begin
                used_reg <= used_reg + 23'd1;
            end
            if (state_reg == bpch_pkg::S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= s_tuser;
            idx_reg   <= s_tdata[11:0];
            pval_reg  <= s_tdata[27:12];
            ppres_reg <= s_tdata[28];
            grm_reg   <= s_tdata[46:29];
            sel_reg   <= s_tdata[54:47];
        end
        case (state_reg)
            bpch_pkg::S_EXEC: begin
                res_status_reg <= bpch_pkg::ST_OK;
                res_bin_reg    <= bpch_pkg::NO_BIN;
                res_cnt_reg    <= '0;
                res_avg_g_reg  <= '0;
                res_avg_c_reg  <= '0;
                j_reg          <= col_reg;
                hit_reg        <= bin_calc;
                case (func_reg)
                    bpch_pkg::FN_LOAD: begin
                        if (load_bad) begin
                            res_status_reg <= bpch_pkg::ST_BAD_IDX;
                        end
                    end
                    bpch_pkg::FN_GRM: begin
                        if (grm_past_end) begin
                            res_status_reg <= bpch_pkg::ST_PAST_END;
                        end else if (grm_skip) begin
                            res_status_reg <= bpch_pkg::ST_SKIPPED;
                        end
                    end
                    bpch_pkg::FN_READ: begin
                        if (read_bad) begin
                            res_status_reg <= bpch_pkg::ST_BAD_IDX;
                        end else begin
                            res_bin_reg <= sel_reg;
                        end
                    end
                    default: res_status_reg <= bpch_pkg::ST_BAD_IDX;
                endcase
            end
            bpch_pkg::S_RD_I: begin
                pi_reg <= prd_reg;
            end
            bpch_pkg::S_RD_J: begin
                prod_reg <= 32'($signed(pi_reg[15:0]) * $signed(prd_reg[15:0]));
                if (pair_missing) begin
                    res_status_reg <= bpch_pkg::ST_SKIPPED;
                end else if (hit_none) begin
                    res_status_reg <= bpch_pkg::ST_RANGE;
                end else begin
                    res_bin_reg <= hit_reg;
                end
            end
            bpch_pkg::S_RD_BIN: begin
                res_cnt_reg <= brd_reg.cnt;
            end
            bpch_pkg::S_DIV_G: begin
                if (div_done) begin
                    res_avg_g_reg <= quo_signed[17:0];
                end
            end
            bpch_pkg::S_DIV_C: begin
                if (div_done) begin
                    res_avg_c_reg <= quo_signed[31:0];
                end
            end
            bpch_pkg::S_OUT: begin
                if (out_free) begin
                    m_user_reg <= res_status_reg;
                    m_data_reg <= {grm_past_end, miss_reg, used_reg, seen_reg,
                                   res_avg_c_reg, res_avg_g_reg, res_cnt_reg, res_bin_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`include "binned_pair_crossproduct_histogram_assert.svh"

    `BPCH_ASSERT(a_no_accept_in_clear, (state_reg == bpch_pkg::S_CLEAR) |-> !s_tready, "accept during clearing pass")
    `BPCH_ASSERT(a_accept_to_exec, accept |=> (state_reg == bpch_pkg::S_EXEC), "accepted item not executed")
    `BPCH_ASSERT(a_acc_bin_valid, (state_reg == bpch_pkg::S_ACC) |-> (hit_reg < 8'(bpch_pkg::NUM_BINS)), "accumulate into no bin")
    `BPCH_ASSERT(a_div_nonzero, div_start |-> (brd_reg.cnt != '0), "division by empty bin count")
    `BPCH_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> (state_reg == bpch_pkg::S_CLEAR), "reset did not start clearing pass")

endmodule
